// File: rtl/core/slpg_pkg.sv
// Shared types, status codes, pattern levels and breathing tables of the status LED generator.
package slpg_pkg;

    localparam int DEF_TICK_STEP_MS     = 20;
    localparam int DEF_BREATH_PERIOD_MS = 1000;

    localparam int TIME_W        = 32;
    localparam int CODE_W        = 4;
    localparam int DUTY_W        = 8;

    localparam logic [CODE_W-1:0] ST_OFF       = 4'd0;
    localparam logic [CODE_W-1:0] ST_INIT      = 4'd1;
    localparam logic [CODE_W-1:0] ST_READY     = 4'd2;
    localparam logic [CODE_W-1:0] ST_CONNECTED = 4'd3;
    localparam logic [CODE_W-1:0] ST_BUSY      = 4'd4;
    localparam logic [CODE_W-1:0] ST_BUSY_ALT  = 4'd5;
    localparam logic [CODE_W-1:0] ST_TRANSFER  = 4'd6;
    localparam logic [CODE_W-1:0] ST_SUCCESS   = 4'd7;
    localparam logic [CODE_W-1:0] ST_ERROR     = 4'd8;
    localparam logic [CODE_W-1:0] FLASH_NONE   = 4'd0;

    localparam logic REQ_TICK   = 1'b0;
    localparam logic REQ_STATUS = 1'b1;

    localparam logic [DUTY_W-1:0] DUTY_OFF      = 8'd255;
    localparam logic [DUTY_W-1:0] LVL_BLINK     = 8'd50;
    localparam logic [DUTY_W-1:0] LVL_SOLID     = 8'd40;
    localparam logic [DUTY_W-1:0] LVL_SUCCESS   = 8'd60;
    localparam logic [DUTY_W-1:0] LVL_ERROR     = 8'd80;

    localparam int BLINK_HALF_MS   = 150;
    localparam int BLINK_PERIOD_MS = 2 * BLINK_HALF_MS;
    localparam int BLINK_PH_W      = $clog2(BLINK_PERIOD_MS);

    localparam int FLASH_LEN_MS  = 600;
    localparam int FLASH_HALF_MS = 100;

    localparam int BREATH_STEPS  = 50;
    localparam int BREATH_IDX_W  = $clog2(BREATH_STEPS);

    localparam logic [DUTY_W-1:0] BREATH_GREEN [BREATH_STEPS] = '{
        8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd1,  8'd1,  8'd2,
        8'd4,  8'd5,  8'd7,  8'd9,  8'd12, 8'd14, 8'd17, 8'd20, 8'd23, 8'd26,
        8'd28, 8'd30, 8'd32, 8'd33, 8'd34, 8'd35, 8'd34, 8'd33, 8'd32, 8'd30,
        8'd28, 8'd26, 8'd23, 8'd20, 8'd17, 8'd14, 8'd12, 8'd9,  8'd7,  8'd5,
        8'd4,  8'd2,  8'd1,  8'd1,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0
    };

    localparam logic [DUTY_W-1:0] BREATH_BLUE [BREATH_STEPS] = '{
        8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd1,  8'd2,  8'd4,
        8'd5,  8'd8,  8'd10, 8'd14, 8'd17, 8'd21, 8'd25, 8'd29, 8'd33, 8'd37,
        8'd40, 8'd44, 8'd46, 8'd48, 8'd49, 8'd50, 8'd49, 8'd48, 8'd46, 8'd44,
        8'd40, 8'd37, 8'd33, 8'd29, 8'd25, 8'd21, 8'd17, 8'd14, 8'd10, 8'd8,
        8'd5,  8'd4,  8'd2,  8'd1,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0
    };

    typedef struct packed {
        logic [TIME_W-1:0]       time_ms;
        logic                    blink_on;
        logic [BREATH_IDX_W-1:0] breath_idx;
    } time_info_t;

    typedef struct packed {
        logic [DUTY_W-1:0] red;
        logic [DUTY_W-1:0] green;
        logic [DUTY_W-1:0] blue;
    } duty_t;

endpackage

// File: rtl/core/slpg_req_if.sv
// Request channel: tick or status-code write.
interface slpg_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [3:0] new_status;

    modport source (output valid, output req_type, output new_status, input ready);
    modport sink   (input valid, input req_type, input new_status, output ready);
endinterface

// File: rtl/core/slpg_duty_if.sv
// Result channel: active-low RGB PWM duties.
interface slpg_duty_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_duty;
    logic [7:0] green_duty;
    logic [7:0] blue_duty;

    modport source (output valid, output red_duty, output green_duty, output blue_duty,
                    input ready);
    modport sink   (input valid, input red_duty, input green_duty, input blue_duty,
                    output ready);
endinterface

// File: rtl/core/slpg_timebase.sv
// Millisecond clock with running blink and breathing phases kept modulo their periods.
module slpg_timebase #(
    parameter int TICK_STEP_MS     = slpg_pkg::DEF_TICK_STEP_MS,
    parameter int BREATH_PERIOD_MS = slpg_pkg::DEF_BREATH_PERIOD_MS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    output slpg_pkg::time_info_t   info
);
    import slpg_pkg::*;

    localparam longint TIME_WRAP = longint'(1) << TIME_W;
    localparam int BR_PH_W  = $clog2(BREATH_PERIOD_MS);

    localparam int BLINK_STEP  = TICK_STEP_MS % BLINK_PERIOD_MS;
    localparam int BLINK_WRAP  = int'(TIME_WRAP % BLINK_PERIOD_MS);
    localparam int BLINK_WSTEP = (BLINK_STEP + BLINK_PERIOD_MS - BLINK_WRAP) % BLINK_PERIOD_MS;

    localparam int BR_STEP  = TICK_STEP_MS % BREATH_PERIOD_MS;
    localparam int BR_WRAP  = int'(TIME_WRAP % BREATH_PERIOD_MS);
    localparam int BR_WSTEP = (BR_STEP + BREATH_PERIOD_MS - BR_WRAP) % BREATH_PERIOD_MS;

    logic [TIME_W-1:0]     time_ms_reg,  time_ms_next;
    logic [BLINK_PH_W-1:0] blink_ph_reg, blink_ph_next;
    logic [BR_PH_W-1:0]    br_ph_reg,    br_ph_next;

    logic [TIME_W:0]       time_sum;
    logic                  wrap;
    logic [BLINK_PH_W:0]   blink_sum;
    logic [BR_PH_W:0]      br_sum;
    logic [BREATH_STEPS-2:0] br_hit;
    logic [BREATH_IDX_W-1:0] br_idx;

    assign time_sum = {1'b0, time_ms_reg} + (TIME_W+1)'(TICK_STEP_MS);
    assign wrap     = time_sum[TIME_W];

    always_comb
    begin
        blink_sum = {1'b0, blink_ph_reg}
                  + (wrap ? (BLINK_PH_W+1)'(BLINK_WSTEP) : (BLINK_PH_W+1)'(BLINK_STEP));
        if (blink_sum >= (BLINK_PH_W+1)'(BLINK_PERIOD_MS))
        begin
            blink_sum = blink_sum - (BLINK_PH_W+1)'(BLINK_PERIOD_MS);
        end
        br_sum = {1'b0, br_ph_reg}
               + (wrap ? (BR_PH_W+1)'(BR_WSTEP) : (BR_PH_W+1)'(BR_STEP));
        if (br_sum >= (BR_PH_W+1)'(BREATH_PERIOD_MS))
        begin
            br_sum = br_sum - (BR_PH_W+1)'(BREATH_PERIOD_MS);
        end
        time_ms_next  = time_ms_reg;
        blink_ph_next = blink_ph_reg;
        br_ph_next    = br_ph_reg;
        if (advance)
        begin
            time_ms_next  = time_sum[TIME_W-1:0];
            blink_ph_next = blink_sum[BLINK_PH_W-1:0];
            br_ph_next    = br_sum[BR_PH_W-1:0];
        end
    end

    // Thermometer of step thresholds: phase * steps >= k * period.
    genvar k;
    generate
        for (k = 1; k < BREATH_STEPS; k++)
        begin : g_thresh
            localparam int TH = (k * BREATH_PERIOD_MS + BREATH_STEPS - 1) / BREATH_STEPS;
            assign br_hit[k-1] = (br_ph_reg >= BR_PH_W'(TH));
        end
    endgenerate

    always_comb
    begin
        br_idx = '0;
        for (int i = 0; i < BREATH_STEPS - 1; i++)
        begin
            if (br_hit[i])
            begin
                br_idx = BREATH_IDX_W'(i + 1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_ms_reg  <= '0;
            blink_ph_reg <= '0;
            br_ph_reg    <= '0;
        end
        else
        begin
            time_ms_reg  <= time_ms_next;
            blink_ph_reg <= blink_ph_next;
            br_ph_reg    <= br_ph_next;
        end
    end

    assign info.time_ms    = time_ms_reg;
    assign info.blink_on   = (blink_ph_reg < BLINK_PH_W'(BLINK_HALF_MS));
    assign info.breath_idx = br_idx;

endmodule

// File: rtl/core/slpg_pattern.sv
// Status and flash state with the per-tick duty selection.
module slpg_pattern (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 set_status,
    input  logic                 tick,
    input  logic [3:0]           new_status,
    input  slpg_pkg::time_info_t info,
    output slpg_pkg::duty_t      duty
);
    import slpg_pkg::*;

    logic [CODE_W-1:0] status_reg,    status_next;
    logic [CODE_W-1:0] return_reg,    return_next;
    logic [CODE_W-1:0] flash_kind_reg, flash_kind_next;
    logic [TIME_W-1:0] flash_start_reg, flash_start_next;
    duty_t             held_reg,      held_next;

    logic              is_flash;
    logic              start_new;
    logic [TIME_W-1:0] elapsed;
    logic              flash_live;
    logic              flash_on;
    logic [DUTY_W-1:0] lvl_r, lvl_g, lvl_b;
    duty_t             fresh;

    assign is_flash   = (status_reg == ST_SUCCESS) || (status_reg == ST_ERROR);
    assign start_new  = (flash_kind_reg != status_reg);
    assign elapsed    = start_new ? '0 : (info.time_ms - flash_start_reg);
    assign flash_live = (elapsed < TIME_W'(FLASH_LEN_MS));
    assign flash_on   = (elapsed < TIME_W'(FLASH_HALF_MS))
                     || ((elapsed >= TIME_W'(2 * FLASH_HALF_MS))
                         && (elapsed < TIME_W'(3 * FLASH_HALF_MS)))
                     || ((elapsed >= TIME_W'(4 * FLASH_HALF_MS))
                         && (elapsed < TIME_W'(5 * FLASH_HALF_MS)));

    always_comb
    begin
        lvl_r = '0;
        lvl_g = '0;
        lvl_b = '0;
        case (status_reg)
            ST_INIT, ST_BUSY, ST_BUSY_ALT:
            begin
                lvl_b = info.blink_on ? LVL_BLINK : '0;
            end
            ST_READY, ST_CONNECTED:
            begin
                lvl_g = LVL_SOLID;
            end
            ST_TRANSFER:
            begin
                lvl_g = BREATH_GREEN[info.breath_idx];
                lvl_b = BREATH_BLUE[info.breath_idx];
            end
            ST_SUCCESS:
            begin
                lvl_g = flash_on ? LVL_SUCCESS : '0;
            end
            ST_ERROR:
            begin
                lvl_r = flash_on ? LVL_ERROR : '0;
            end
            default:
            begin
                lvl_r = '0;
            end
        endcase
    end

    assign fresh.red   = DUTY_OFF - lvl_r;
    assign fresh.green = DUTY_OFF - lvl_g;
    assign fresh.blue  = DUTY_OFF - lvl_b;

    assign duty = (is_flash && !flash_live) ? held_reg : fresh;

    always_comb
    begin
        status_next      = status_reg;
        return_next      = return_reg;
        flash_kind_next  = flash_kind_reg;
        flash_start_next = flash_start_reg;
        held_next        = held_reg;
        if (set_status)
        begin
            status_next = new_status;
        end
        else if (tick)
        begin
            if (is_flash)
            begin
                if (flash_live)
                begin
                    flash_kind_next = status_reg;
                    held_next       = fresh;
                    if (start_new)
                    begin
                        flash_start_next = info.time_ms;
                    end
                end
                else
                begin
                    flash_kind_next = FLASH_NONE;
                    status_next     = return_reg;
                end
            end
            else
            begin
                return_next     = status_reg;
                flash_kind_next = FLASH_NONE;
                held_next       = fresh;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg      <= ST_OFF;
            return_reg      <= ST_READY;
            flash_kind_reg  <= FLASH_NONE;
            flash_start_reg <= '0;
            held_reg        <= '{red: DUTY_OFF, green: DUTY_OFF, blue: DUTY_OFF};
        end
        else
        begin
            status_reg      <= status_next;
            return_reg      <= return_next;
            flash_kind_reg  <= flash_kind_next;
            flash_start_reg <= flash_start_next;
            held_reg        <= held_next;
        end
    end

endmodule

// File: rtl/core/slpg_out_buf.sv
// Two-entry result register with skid slot.
module slpg_out_buf (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  slpg_pkg::duty_t push_data,
    output logic            can_push,
    output logic            out_valid,
    input  logic            out_ready,
    output slpg_pkg::duty_t out_data
);
    import slpg_pkg::*;

    logic  head_valid_reg, head_valid_next;
    logic  skid_valid_reg, skid_valid_next;
    duty_t head_reg, head_next;
    duty_t skid_reg, skid_next;
    logic  pop;

    assign pop = head_valid_reg && out_ready;

    always_comb
    begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                head_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                head_next = push_data;
            end
            else
            begin
                head_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!head_valid_reg)
            begin
                head_next       = push_data;
                head_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign can_push  = !skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_data  = head_reg;

endmodule

// File: rtl/core/status_led_pattern_generator.sv
// Status LED pattern generator top level: request in, active-low RGB duties out.
//
//  channel  dir  fields                              per request
//  req      in   req_type, new_status                tick or status write
//  duty     out  red_duty, green_duty, blue_duty     one per tick, none per write
//
//  One request per cycle while req.ready is high; a tick's duties are registered.
//  The duty selection is one pass of logic from the state registers to the result register.
//  A two-entry result buffer keeps req.ready high while one result waits on duty.ready.
//  req.ready drops only while two results are held.
//  Reset: status off, return code ready, clock and phases at zero, held duties all off.
module status_led_pattern_generator #(
    parameter int TICK_STEP_MS     = slpg_pkg::DEF_TICK_STEP_MS,
    parameter int BREATH_PERIOD_MS = slpg_pkg::DEF_BREATH_PERIOD_MS
) (
    input  logic        clk,
    input  logic        rst_n,
    slpg_req_if.sink    req,
    slpg_duty_if.source duty
);
    import slpg_pkg::*;

    logic       accept;
    logic       tick;
    logic       set_status;
    logic       can_push;
    time_info_t info;
    duty_t      duty_now;
    duty_t      duty_out;

    assign req.ready  = can_push;
    assign accept     = req.valid && can_push;
    assign tick       = accept && (req.req_type == REQ_TICK);
    assign set_status = accept && (req.req_type == REQ_STATUS);

    slpg_timebase #(
        .TICK_STEP_MS     (TICK_STEP_MS),
        .BREATH_PERIOD_MS (BREATH_PERIOD_MS)
    ) u_timebase (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (tick),
        .info    (info)
    );

    slpg_pattern u_pattern (
        .clk        (clk),
        .rst_n      (rst_n),
        .set_status (set_status),
        .tick       (tick),
        .new_status (req.new_status),
        .info       (info),
        .duty       (duty_now)
    );

    slpg_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (tick),
        .push_data (duty_now),
        .can_push  (can_push),
        .out_valid (duty.valid),
        .out_ready (duty.ready),
        .out_data  (duty_out)
    );

    assign duty.red_duty   = duty_out.red;
    assign duty.green_duty = duty_out.green;
    assign duty.blue_duty  = duty_out.blue;

`ifndef SYNTHESIS
    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !duty.valid |-> req.ready)
        else $error("result buffer empty but request refused");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (set_status && !duty.valid) |=> !duty.valid)
        else $error("status write produced a result");

    a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (tick && !duty.valid) |=> duty.valid)
        else $error("tick did not produce a result");
`endif

endmodule

// File: dv/status_led_pattern_generator_test.sv
// Self-checking testbench for the status LED pattern generator: directed and random requests.
`timescale 1ns / 1ps

module status_led_pattern_generator_test;
    import slpg_pkg::*;

    localparam int TICK_MS   = DEF_TICK_STEP_MS;
    localparam int PERIOD_MS = DEF_BREATH_PERIOD_MS;

    localparam logic [CODE_W-1:0] ST_UNKNOWN_LOW = 4'd9;
    localparam logic [CODE_W-1:0] ST_UNKNOWN_TOP = 4'd15;

    localparam int PHASE_ITEMS = 210;

    localparam logic [7:0] GREEN_STEP [BREATH_STEPS] = '{
        0, 0, 0, 0, 0, 0, 0, 1, 1, 2, 4, 5, 7, 9, 12, 14, 17, 20, 23, 26, 28,
        30, 32, 33, 34, 35, 34, 33, 32, 30, 28, 26, 23, 20, 17, 14, 12, 9, 7,
        5, 4, 2, 1, 1, 0, 0, 0, 0, 0, 0
    };
    localparam logic [7:0] BLUE_STEP [BREATH_STEPS] = '{
        0, 0, 0, 0, 0, 0, 0, 1, 2, 4, 5, 8, 10, 14, 17, 21, 25, 29, 33, 37, 40,
        44, 46, 48, 49, 50, 49, 48, 46, 44, 40, 37, 33, 29, 25, 21, 17, 14, 10,
        8, 5, 4, 2, 1, 0, 0, 0, 0, 0, 0
    };

    typedef struct {
        logic              rt;
        logic [CODE_W-1:0] code;
        bit                known;
        duty_t             want;
    } script_row_t;

    localparam int N_SCRIPT = 23;
    script_row_t script [N_SCRIPT] = '{
        '{REQ_TICK,   ST_OFF,         1'b1, 24'hFF_FF_FF},
        '{REQ_STATUS, ST_INIT,        1'b0, 24'h0},
        '{REQ_TICK,   ST_OFF,         1'b1, 24'hFF_FF_CD},
        '{REQ_STATUS, ST_READY,       1'b0, 24'h0},
        '{REQ_TICK,   ST_OFF,         1'b1, 24'hFF_D7_FF},
        '{REQ_STATUS, ST_CONNECTED,   1'b0, 24'h0},
        '{REQ_TICK,   ST_OFF,         1'b1, 24'hFF_D7_FF},
        '{REQ_STATUS, ST_BUSY,        1'b0, 24'h0},
        '{REQ_TICK,   ST_OFF,         1'b0, 24'h0},
        '{REQ_STATUS, ST_BUSY_ALT,    1'b0, 24'h0},
        '{REQ_TICK,   ST_OFF,         1'b0, 24'h0},
        '{REQ_STATUS, ST_TRANSFER,    1'b0, 24'h0},
        '{REQ_TICK,   ST_OFF,         1'b0, 24'h0},
        '{REQ_STATUS, ST_UNKNOWN_TOP, 1'b0, 24'h0},
        '{REQ_TICK,   ST_OFF,         1'b1, 24'hFF_FF_FF},
        '{REQ_STATUS, ST_SUCCESS,     1'b0, 24'h0},
        '{REQ_TICK,   ST_OFF,         1'b1, 24'hFF_C3_FF},
        '{REQ_STATUS, ST_SUCCESS,     1'b0, 24'h0},
        '{REQ_TICK,   ST_OFF,         1'b0, 24'h0},
        '{REQ_STATUS, ST_ERROR,       1'b0, 24'h0},
        '{REQ_TICK,   ST_OFF,         1'b1, 24'hAF_FF_FF},
        '{REQ_STATUS, ST_OFF,         1'b0, 24'h0},
        '{REQ_TICK,   ST_OFF,         1'b1, 24'hFF_FF_FF}
    };

    logic clk;
    logic rst_n;

    slpg_req_if  req_ch ();
    slpg_duty_if duty_ch ();

    status_led_pattern_generator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .duty  (duty_ch)
    );

    logic [CODE_W-1:0] cur_code;
    logic [CODE_W-1:0] steady_code;
    logic [CODE_W-1:0] flash_code;
    logic [TIME_W-1:0] flash_t0;
    logic [TIME_W-1:0] clock_ms;
    duty_t             last_duty;

    duty_t duties_due [$];

    int mismatches;
    int requests_sent;
    int ticks_sent;
    int results_seen;
    int flashes_ended;
    int snd_idle_pct;
    int rcv_idle_pct;
    int hold_left;
    bit long_hold_done;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d duty results still due", duties_due.size());
        $display("status_led_pattern_generator_test NOT OK");
        $finish;
    end

    function automatic duty_t lit(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        duty_t d;
        d.red   = DUTY_OFF - r;
        d.green = DUTY_OFF - g;
        d.blue  = DUTY_OFF - b;
        last_duty = d;
        return d;
    endfunction

    function automatic bit led_pattern_step(input logic rt, input logic [CODE_W-1:0] code,
                                            output duty_t d);
        logic [TIME_W-1:0] elapsed;
        logic [CODE_W-1:0] st;
        bit                on;
        int                idx;
        if (rt == REQ_STATUS)
        begin
            cur_code = code;
            return 1'b0;
        end
        st = cur_code;
        if (st == ST_SUCCESS || st == ST_ERROR)
        begin
            if (flash_code != st)
            begin
                flash_code = st;
                flash_t0   = clock_ms;
            end
            elapsed = clock_ms - flash_t0;
            if (elapsed < FLASH_LEN_MS)
            begin
                on = ((elapsed / FLASH_HALF_MS) % 2) == 0;
                if (st == ST_SUCCESS)
                    d = lit(8'd0, on ? LVL_SUCCESS : 8'd0, 8'd0);
                else
                    d = lit(on ? LVL_ERROR : 8'd0, 8'd0, 8'd0);
            end
            else
            begin
                flash_code = FLASH_NONE;
                cur_code   = steady_code;
                d          = last_duty;
                flashes_ended++;
            end
        end
        else
        begin
            steady_code = st;
            flash_code  = FLASH_NONE;
            case (st)
                ST_INIT, ST_BUSY, ST_BUSY_ALT:
                begin
                    on = ((clock_ms / BLINK_HALF_MS) % 2) == 0;
                    d  = lit(8'd0, 8'd0, on ? LVL_BLINK : 8'd0);
                end
                ST_READY, ST_CONNECTED:
                    d = lit(8'd0, LVL_SOLID, 8'd0);
                ST_TRANSFER:
                begin
                    idx = ((clock_ms % PERIOD_MS) * BREATH_STEPS) / PERIOD_MS;
                    if (idx >= BREATH_STEPS)
                        idx = BREATH_STEPS - 1;
                    d = lit(8'd0, GREEN_STEP[idx], BLUE_STEP[idx]);
                end
                default:
                    d = lit(8'd0, 8'd0, 8'd0);
            endcase
        end
        clock_ms = clock_ms + TICK_MS;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        $display("MISMATCH %0t: %s expected %0d got %0d", $time, what, want, got);
        mismatches++;
    endtask

    task automatic send_request(input logic rt, input logic [CODE_W-1:0] code,
                                input bit known, input duty_t want);
        duty_t d;
        while ($urandom_range(99) < snd_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= rt;
        req_ch.new_status <= code;
        do
            @(posedge clk);
        while (!req_ch.ready);
        requests_sent++;
        if (led_pattern_step(rt, code, d))
        begin
            ticks_sent++;
            duties_due.push_back(known ? want : d);
        end
        @(negedge clk);
    endtask

    task automatic send_status(input logic [CODE_W-1:0] code);
        send_request(REQ_STATUS, code, 1'b0, '0);
    endtask

    task automatic send_tick();
        send_request(REQ_TICK, CODE_W'($urandom_range(15)), 1'b0, '0);
    endtask

    task automatic run_random(input int n_items);
        int stop_at;
        int kind;
        int n;
        logic [CODE_W-1:0] code;
        stop_at = requests_sent + n_items;
        while (requests_sent < stop_at)
        begin
            kind = $urandom_range(99);
            if (kind < 15)
                send_request(1'($urandom_range(1)), CODE_W'($urandom_range(15)), 1'b0, '0);
            else if (kind < 40)
            begin
                send_status($urandom_range(1) ? ST_SUCCESS : ST_ERROR);
                n = $urandom_range(40, 3);
                for (int i = 0; i < n; i++)
                begin
                    if (i == n / 2 && $urandom_range(3) == 0)
                        send_status(CODE_W'($urandom_range(ST_ERROR, ST_OFF)));
                    send_tick();
                end
            end
            else
            begin
                if ($urandom_range(99) < 80)
                    code = CODE_W'($urandom_range(ST_TRANSFER, ST_OFF));
                else
                    code = CODE_W'($urandom_range(ST_UNKNOWN_TOP, ST_UNKNOWN_LOW));
                send_status(code);
                n = $urandom_range(25, 1);
                for (int i = 0; i < n; i++)
                    send_tick();
            end
        end
    endtask

    initial
    begin
        duty_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!long_hold_done && results_seen >= 60)
            begin
                long_hold_done = 1'b1;
                hold_left      = 120;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                duty_ch.ready <= 1'b0;
            end
            else
                duty_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        duty_t want;
        if (rst_n && duty_ch.valid && duty_ch.ready)
        begin
            results_seen++;
            if (duties_due.size() == 0)
            begin
                report_mismatch("red_duty of a result with none due", DUTY_OFF,
                                duty_ch.red_duty);
            end
            else
            begin
                want = duties_due.pop_front();
                if (duty_ch.red_duty !== want.red)
                    report_mismatch("red_duty", want.red, duty_ch.red_duty);
                if (duty_ch.green_duty !== want.green)
                    report_mismatch("green_duty", want.green, duty_ch.green_duty);
                if (duty_ch.blue_duty !== want.blue)
                    report_mismatch("blue_duty", want.blue, duty_ch.blue_duty);
            end
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_TICK;
        req_ch.new_status = ST_OFF;
        cur_code          = ST_OFF;
        steady_code       = ST_READY;
        flash_code        = FLASH_NONE;
        flash_t0          = '0;
        clock_ms          = '0;
        last_duty         = {DUTY_OFF, DUTY_OFF, DUTY_OFF};
        snd_idle_pct      = 0;
        rcv_idle_pct      = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_SCRIPT; i++)
            send_request(script[i].rt, script[i].code, script[i].known, script[i].want);

        snd_idle_pct = 33;
        rcv_idle_pct = 53;
        run_random(PHASE_ITEMS);
        snd_idle_pct = 53;
        rcv_idle_pct = 33;
        run_random(PHASE_ITEMS);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        run_random(PHASE_ITEMS);
        req_ch.valid <= 1'b0;

        while (duties_due.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);

        $display("covered %0d requests: %0d ticks, %0d status writes, %0d duty results",
                 requests_sent, ticks_sent, requests_sent - ticks_sent, results_seen);
        $display("every status code, %0d completed flashes, one long output stall",
                 flashes_ended);
        if (mismatches == 0)
            $display("status_led_pattern_generator_test OK");
        else
            $display("status_led_pattern_generator_test NOT OK");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/slpg_pkg.sv
rtl/core/slpg_req_if.sv
rtl/core/slpg_duty_if.sv
rtl/core/slpg_timebase.sv
rtl/core/slpg_pattern.sv
rtl/core/slpg_out_buf.sv
rtl/core/status_led_pattern_generator.sv
dv/status_led_pattern_generator_test.sv
